FILE: design/skf_pkg.sv
`timescale 1ns / 1ps

package skf_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned GAIN_W   = 17;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned STEP_W   = 3;
	localparam int unsigned CNT_W    = 4;

	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'd1;

	localparam logic [DATA_W-1:0] PROCESS_NOISE_RST     = 32'd1310720;
	localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RST = 32'd13107200;

	// Gain of one in Q1.16.
	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

	// The first divide step settles the integer quotient bit; the loop then
	// produces the sixteen fraction bits.
	localparam logic [CNT_W-1:0] DIV_LAST = 4'd15;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE    = 3'd0;
	localparam step_t STEP_DIV     = 3'd4;
	localparam step_t STEP_MUL_EST = 3'd5;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_DEN,
		OP_DIV0,
		OP_DIV,
		OP_MUL_EST,
		OP_MUL_VAR,
		OP_OUT
	} op_t;

	typedef enum logic [2:0] {
		COND_NONE,
		COND_WAIT_IN,
		COND_WAIT_OUT,
		COND_DEN_ZERO,
		COND_DIV_MORE
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic den_zero;
	} status_t;

	typedef struct packed {
		op_t  op;
		logic in_ready;
	} ctrl_t;

	// Microprogram. A step without a jump falls through to the next one; the
	// last step wraps around to the idle step.
	function automatic uword_t ucode(input step_t step);
		uword_t w;
		w = '{op: OP_NOP, cond: COND_NONE, target: STEP_IDLE};
		case (step)
			3'd0: w = '{op: OP_LOAD,    cond: COND_WAIT_IN,  target: STEP_IDLE};
			3'd1: w = '{op: OP_DEN,     cond: COND_NONE,     target: STEP_IDLE};
			3'd2: w = '{op: OP_NOP,     cond: COND_DEN_ZERO, target: STEP_MUL_EST};
			3'd3: w = '{op: OP_DIV0,    cond: COND_NONE,     target: STEP_IDLE};
			3'd4: w = '{op: OP_DIV,     cond: COND_DIV_MORE, target: STEP_DIV};
			3'd5: w = '{op: OP_MUL_EST, cond: COND_NONE,     target: STEP_IDLE};
			3'd6: w = '{op: OP_MUL_VAR, cond: COND_NONE,     target: STEP_IDLE};
			3'd7: w = '{op: OP_OUT,     cond: COND_WAIT_OUT, target: STEP_IDLE};
			default: w = '{op: OP_NOP, cond: COND_NONE, target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

FILE: design/skf_sample_if.sv
`timescale 1ns / 1ps

interface skf_sample_if;
	logic                               valid;
	logic                               ready;
	logic signed [skf_pkg::DATA_W-1:0]  sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

FILE: design/skf_result_if.sv
`timescale 1ns / 1ps

interface skf_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [skf_pkg::DATA_W-1:0]  estimate;
	logic [skf_pkg::GAIN_W-1:0]         gain;

	modport source (output valid, output estimate, output gain, input ready);
	modport sink (input valid, input estimate, input gain, output ready);
endinterface

FILE: design/skf_cfg_if.sv
`timescale 1ns / 1ps

interface skf_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [skf_pkg::CFG_IDX_W-1:0]      index;
	logic [skf_pkg::DATA_W-1:0]         data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/scalar_kalman_filter_core.sv
`timescale 1ns / 1ps

// One-dimensional Kalman filter on signed Q16.16 sensor samples.
// samples: one sample per transfer. results: the new estimate (signed Q16.16)
// and the gain used for it (Q1.16, 65536 is one), one per sample, in order.
// cfg: register 0 is the process noise Q, register 1 the measurement noise R,
// both unsigned Q16.16; always ready, write only while no sample is in work.
// A microcoded sequencer steps a shared datapath: one predict step, one
// denominator step, a bit-per-cycle restoring divide of 17 steps for the
// gain, and two passes through one 18 x 33 multiplier. A sample is taken
// only while the sequencer sits in its idle step; its result is loaded into
// the output register in the last step (the divide is skipped when P + R is zero),
// and the next sample can be taken in the following cycle.
// The output register holds one result. If the receiver stalls, the next
// sample is still taken and worked up to its last step, which then waits
// until the held result has been transferred.
// Reset clears the estimate and the variance to zero and loads Q = 20.0 and
// R = 200.0; the output register comes up empty.
module scalar_kalman_filter_core (
	input  logic              clk,
	input  logic              arst_n,
	skf_sample_if.sink        samples,
	skf_result_if.source      results,
	skf_cfg_if.sink           cfg
);

	logic [skf_pkg::DATA_W-1:0]         process_noise_q;
	logic [skf_pkg::DATA_W-1:0]         measurement_noise_q;
	logic                               out_valid_q;
	logic signed [skf_pkg::DATA_W-1:0]  out_estimate_q;
	logic [skf_pkg::GAIN_W-1:0]         out_gain_q;

	skf_pkg::status_t                   status;
	skf_pkg::ctrl_t                     ctrl;
	logic signed [skf_pkg::DATA_W-1:0]  estimate;
	logic [skf_pkg::GAIN_W-1:0]         gain;
	logic                               den_zero;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_noise_q     <= skf_pkg::PROCESS_NOISE_RST;
			measurement_noise_q <= skf_pkg::MEASUREMENT_NOISE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				skf_pkg::REG_PROCESS_NOISE:     process_noise_q     <= cfg.data;
				skf_pkg::REG_MEASUREMENT_NOISE: measurement_noise_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign status.in_valid = samples.valid;
	assign status.out_free = !out_valid_q || results.ready;
	assign status.den_zero = den_zero;

	skf_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	skf_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.op                (ctrl.op),
		.sample            (samples.sample),
		.process_noise     (process_noise_q),
		.measurement_noise (measurement_noise_q),
		.estimate          (estimate),
		.gain              (gain),
		.den_zero          (den_zero)
	);

	assign samples.ready = ctrl.in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == skf_pkg::OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == skf_pkg::OP_OUT) begin
			out_estimate_q <= estimate;
			out_gain_q     <= gain;
		end
	end

	assign results.valid    = out_valid_q;
	assign results.estimate = out_estimate_q;
	assign results.gain     = out_gain_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> !samples.ready)
		else $error("sequencer stayed idle after a sample transfer");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == skf_pkg::OP_OUT |-> (!out_valid_q || results.ready))
		else $error("result loaded over one not yet transferred");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.gain <= skf_pkg::GAIN_ONE)
		else $error("gain above one");

	a_zero_den_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == skf_pkg::OP_OUT && den_zero |-> gain == '0)
		else $error("nonzero gain with a zero denominator");

endmodule

FILE: design/skf_sequencer.sv
`timescale 1ns / 1ps

module skf_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  skf_pkg::status_t  status,
	output skf_pkg::ctrl_t    ctrl
);

	skf_pkg::step_t                step_q;
	skf_pkg::step_t                step_d;
	logic [skf_pkg::CNT_W-1:0]     cnt_q;
	skf_pkg::uword_t               uw;
	logic                          stall;
	logic                          jump;

	assign uw = skf_pkg::ucode(step_q);

	always_comb begin
		stall = ((uw.cond == skf_pkg::COND_WAIT_IN) && !status.in_valid) ||
			((uw.cond == skf_pkg::COND_WAIT_OUT) && !status.out_free);
		jump = ((uw.cond == skf_pkg::COND_DEN_ZERO) && status.den_zero) ||
			((uw.cond == skf_pkg::COND_DIV_MORE) && (cnt_q != skf_pkg::DIV_LAST));
		if (stall) begin
			step_d = step_q;
		end else if (jump) begin
			step_d = uw.target;
		end else begin
			step_d = step_q + 1'b1;
		end
	end

	always_comb begin
		ctrl.op       = stall ? skf_pkg::OP_NOP : uw.op;
		ctrl.in_ready = (step_q == skf_pkg::STEP_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= skf_pkg::STEP_IDLE;
			cnt_q  <= '0;
		end else begin
			step_q <= step_d;
			if (ctrl.op == skf_pkg::OP_DEN) begin
				cnt_q <= '0;
			end else if (ctrl.op == skf_pkg::OP_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

FILE: design/skf_datapath.sv
`timescale 1ns / 1ps

module skf_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  skf_pkg::op_t                       op,
	input  logic signed [skf_pkg::DATA_W-1:0]  sample,
	input  logic [skf_pkg::DATA_W-1:0]         process_noise,
	input  logic [skf_pkg::DATA_W-1:0]         measurement_noise,
	output logic signed [skf_pkg::DATA_W-1:0]  estimate,
	output logic [skf_pkg::GAIN_W-1:0]         gain,
	output logic                               den_zero
);

	localparam int unsigned W = skf_pkg::DATA_W;

	logic signed [W-1:0]   est_q;
	logic [W-1:0]          var_q;
	logic [W-1:0]          pred_q;
	logic signed [W:0]     innov_q;
	logic [W:0]            den_q;
	logic [W+1:0]          rem_q;
	logic [skf_pkg::GAIN_W-1:0] gain_q;
	logic signed [W+18:0]  prod_q;

	logic [W:0]            pred_sum;
	logic [W+1:0]          rem_sh;
	logic [W+2:0]          trial;
	logic                  qbit;
	logic signed [17:0]    mul_a;
	logic signed [W:0]     mul_b;
	logic signed [W+18:0]  mul_p;

	assign pred_sum = {1'b0, var_q} + {1'b0, process_noise};

	// Restoring divide: the first step compares without a shift.
	assign rem_sh = (op == skf_pkg::OP_DIV) ? {rem_q[W:0], 1'b0} : rem_q;
	assign trial  = {1'b0, rem_sh} - {2'b00, den_q};
	assign qbit   = !trial[W+2];

	always_comb begin
		if (op == skf_pkg::OP_MUL_VAR) begin
			mul_a = 18'(skf_pkg::GAIN_ONE) - {1'b0, gain_q};
			mul_b = {1'b0, pred_q};
		end else begin
			mul_a = {1'b0, gain_q};
			mul_b = innov_q;
		end
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= '0;
			var_q <= '0;
		end else begin
			// The corrected estimate always fits 32 bits, so the low word of
			// the floored correction is enough.
			if (op == skf_pkg::OP_MUL_VAR) begin
				est_q <= est_q + prod_q[W+15:16];
			end
			if (op == skf_pkg::OP_OUT) begin
				var_q <= prod_q[W+15:16];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			skf_pkg::OP_LOAD: begin
				pred_q  <= pred_sum[W] ? '1 : pred_sum[W-1:0];
				innov_q <= {sample[W-1], sample} - {est_q[W-1], est_q};
			end
			skf_pkg::OP_DEN: begin
				den_q  <= {1'b0, pred_q} + {1'b0, measurement_noise};
				rem_q  <= {2'b00, pred_q};
				gain_q <= '0;
			end
			skf_pkg::OP_DIV0, skf_pkg::OP_DIV: begin
				rem_q  <= qbit ? trial[W+1:0] : rem_sh;
				gain_q <= {gain_q[skf_pkg::GAIN_W-2:0], qbit};
			end
			skf_pkg::OP_MUL_EST, skf_pkg::OP_MUL_VAR: begin
				prod_q <= mul_p;
			end
			default: begin
			end
		endcase
	end

	assign estimate = est_q;
	assign gain     = gain_q;
	assign den_zero = (den_q == '0);

endmodule
